>>> src/small_matrix_inverse_assert.svh
// Assertion macros for the small matrix inverse block.
// Used by the checker; expects clk and arst_n in the scope of use.
`ifndef SMALL_MATRIX_INVERSE_ASSERT_SVH
`define SMALL_MATRIX_INVERSE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/smi_pkg.sv
// Shared widths, codes and structures of the small matrix inverse.
// No dependencies; imported by every module of the block.
`default_nettype none

package smi_pkg;

	localparam int ENT_W     = 32;
	localparam int N_ENT     = 9;
	localparam int ADJ_W     = 64;
	localparam int TERM_W    = 96;
	localparam int DET_W     = 98;
	localparam int DMAG_W    = 97;
	localparam int Q_W       = 33;
	localparam int DIV_STEPS = Q_W;
	localparam int LANE_LAT  = DIV_STEPS + 2;
	localparam int TDATA_W   = N_ENT * ENT_W;

	localparam logic [1:0] SIZE_2X2 = 2'd2;
	localparam logic [1:0] SIZE_RST = 2'd3;

	typedef logic signed [ENT_W-1:0] ent_t;
	typedef logic [ADJ_W-1:0] amag_t;
	typedef logic [DMAG_W-1:0] dmag_t;

	typedef struct packed {
		logic valid;
		logic singular;
	} ctl_t;

	typedef struct packed {
		logic valid;
		logic singular;
		dmag_t dmag;
		logic [N_ENT-1:0] neg;
		amag_t [N_ENT-1:0] amag;
	} cof_t;

	typedef struct packed {
		logic singular;
		logic [N_ENT-1:0][ENT_W-1:0] inv;
	} res_t;

endpackage

`default_nettype wire

>>> src/smi_front.sv
// Front end of the inverse: cofactors, determinant and magnitudes over seven stages.
// Depends on smi_pkg.
`default_nettype none

module smi_front import smi_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [TDATA_W-1:0] in_data,
	input  wire logic mode_2x2,
	output cof_t cof
);

	// Operand indexes of the two products of each cofactor.
	localparam logic [3:0] CF_IDX [N_ENT][4] = '{
		'{4'd4, 4'd8, 4'd7, 4'd5},
		'{4'd2, 4'd7, 4'd1, 4'd8},
		'{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8},
		'{4'd0, 4'd8, 4'd2, 4'd6},
		'{4'd3, 4'd2, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd6, 4'd4},
		'{4'd6, 4'd1, 4'd0, 4'd7},
		'{4'd0, 4'd4, 4'd3, 4'd1}
	};

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic m2_s1, m2_s2, m2_s3, m2_s4, m2_s5;

	ent_t m_s1 [N_ENT];
	ent_t m_s2 [N_ENT];
	logic signed [ADJ_W-1:0] pa_s2 [N_ENT];
	logic signed [ADJ_W-1:0] pb_s2 [N_ENT];

	logic signed [ADJ_W-1:0] adj_s3 [N_ENT];
	logic signed [ADJ_W-1:0] adj_s4 [N_ENT];
	logic signed [ADJ_W-1:0] adj_s5 [N_ENT];
	logic signed [ADJ_W-1:0] adj_s6 [N_ENT];
	logic signed [ADJ_W-1:0] c_s3 [3];
	ent_t a_s3 [3];
	logic signed [ADJ_W-1:0] det2_s3, det2_s4, det2_s5;

	logic signed [ADJ_W:0] lo_s4 [3];
	logic signed [ADJ_W-1:0] hi_s4 [3];
	logic signed [TERM_W-1:0] term_s5 [3];
	logic signed [DET_W-1:0] det_s6;

	logic sing_s7;
	dmag_t dmag_s7;
	logic [N_ENT-1:0] neg_s7;
	amag_t [N_ENT-1:0] amag_s7;

	logic signed [ADJ_W-1:0] cof3 [N_ENT];
	logic signed [ADJ_W-1:0] adj2 [N_ENT];
	logic signed [DET_W-1:0] det_neg;
	logic signed [ADJ_W-1:0] adj_neg [N_ENT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_comb begin
		for (int k = 0; k < N_ENT; k++) begin
			cof3[k] = pa_s2[k] - pb_s2[k];
			adj2[k] = '0;
		end
		adj2[0] = ADJ_W'(m_s2[4]);
		adj2[1] = -ADJ_W'(m_s2[1]);
		adj2[3] = -ADJ_W'(m_s2[3]);
		adj2[4] = ADJ_W'(m_s2[0]);
		det_neg = -det_s6;
		for (int k = 0; k < N_ENT; k++) begin
			adj_neg[k] = -adj_s6[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: capture the matrix.
			for (int k = 0; k < N_ENT; k++) begin
				m_s1[k] <= $signed(in_data[k*ENT_W +: ENT_W]);
			end
			m2_s1 <= mode_2x2;

			// Stage 2: the eighteen products of the 3x3 cofactors.
			for (int k = 0; k < N_ENT; k++) begin
				pa_s2[k] <= m_s1[CF_IDX[k][0]] * m_s1[CF_IDX[k][1]];
				pb_s2[k] <= m_s1[CF_IDX[k][2]] * m_s1[CF_IDX[k][3]];
				m_s2[k] <= m_s1[k];
			end
			m2_s2 <= m2_s1;

			// Stage 3: cofactors wrap to 64 bits; the 2x2 adjugate swaps the diagonal and negates the other two entries.
			for (int k = 0; k < N_ENT; k++) begin
				adj_s3[k] <= m2_s2 ? adj2[k] : cof3[k];
			end
			c_s3[0] <= cof3[0];
			c_s3[1] <= cof3[3];
			c_s3[2] <= cof3[6];
			for (int j = 0; j < 3; j++) begin
				a_s3[j] <= m_s2[j];
			end
			det2_s3 <= cof3[8];
			m2_s3 <= m2_s2;

			// Stage 4: first-row entry times cofactor, split into two halves.
			for (int j = 0; j < 3; j++) begin
				lo_s4[j] <= a_s3[j] * $signed({1'b0, c_s3[j][31:0]});
				hi_s4[j] <= a_s3[j] * $signed(c_s3[j][ADJ_W-1:32]);
			end
			adj_s4 <= adj_s3;
			det2_s4 <= det2_s3;
			m2_s4 <= m2_s3;

			// Stage 5: join the halves into exact 96-bit terms.
			for (int j = 0; j < 3; j++) begin
				term_s5[j] <= (TERM_W'(hi_s4[j]) <<< 32) + TERM_W'(lo_s4[j]);
			end
			adj_s5 <= adj_s4;
			det2_s5 <= det2_s4;
			m2_s5 <= m2_s4;

			// Stage 6: determinant.
			det_s6 <= m2_s5 ? DET_W'(det2_s5)
				: DET_W'(term_s5[0]) + DET_W'(term_s5[1]) + DET_W'(term_s5[2]);
			adj_s6 <= adj_s5;

			// Stage 7: magnitudes and quotient signs for the divider lanes.
			sing_s7 <= (det_s6 == '0);
			dmag_s7 <= det_s6[DET_W-1] ? det_neg[DMAG_W-1:0] : det_s6[DMAG_W-1:0];
			for (int k = 0; k < N_ENT; k++) begin
				amag_s7[k] <= adj_s6[k][ADJ_W-1] ? adj_neg[k] : adj_s6[k];
				neg_s7[k] <= adj_s6[k][ADJ_W-1] ^ det_s6[DET_W-1];
			end
		end
	end

	assign cof = '{valid: v_s7, singular: sing_s7, dmag: dmag_s7, neg: neg_s7,
		amag: amag_s7};

endmodule

`default_nettype wire

>>> src/smi_div.sv
// One divider lane: rounded, saturated adjugate * 2^32 / determinant.
// Restoring division, one quotient bit per stage. Depends on smi_pkg.
`default_nettype none

module smi_div import smi_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  wire amag_t amag,
	input  wire logic neg,
	input  wire dmag_t dmag_in,
	input  wire dmag_t dmag_stg [DIV_STEPS],
	output logic [ENT_W-1:0] res
);

	logic [DMAG_W:0] rem_s [DIV_STEPS+1];
	logic [Q_W-1:0] q_s [DIV_STEPS+1];
	logic ovf_s [DIV_STEPS+1];
	logic neg_s [DIV_STEPS+1];
	logic [ENT_W-1:0] res_s;

	logic [Q_W-1:0] qf;
	logic sat;
	logic [ENT_W-1:0] rq;

	// The numerator is |adj| * 2^33 and its low 33 bits are zero, so the
	// remainder starts at |adj|; a start value not below the divisor means
	// the quotient needs more than 33 bits.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= (DMAG_W+1)'(amag);
			q_s[0] <= '0;
			ovf_s[0] <= (DMAG_W'(amag) >= dmag_in);
			neg_s[0] <= neg;
		end
	end

	for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
		logic [DMAG_W:0] sh;
		logic ge;

		always_comb begin
			sh = {rem_s[s-1][DMAG_W-1:0], 1'b0};
			ge = (sh >= {1'b0, dmag_stg[s-1]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s] <= ge ? sh - {1'b0, dmag_stg[s-1]} : sh;
				q_s[s] <= {q_s[s-1][Q_W-2:0], ge};
				ovf_s[s] <= ovf_s[s-1];
				neg_s[s] <= neg_s[s-1];
			end
		end
	end

	// The 33-bit quotient carries one extra bit, so rounding is (q + 1) / 2.
	always_comb begin
		qf = q_s[DIV_STEPS];
		sat = ovf_s[DIV_STEPS] | qf[Q_W-1] | (&qf[Q_W-2:0]);
		rq = qf[Q_W-1:1] + {{(ENT_W-1){1'b0}}, qf[0]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sat) begin
				res_s <= neg_s[DIV_STEPS] ? {1'b1, {(ENT_W-1){1'b0}}}
					: {1'b0, {(ENT_W-1){1'b1}}};
			end else begin
				res_s <= neg_s[DIV_STEPS] ? -rq : rq;
			end
		end
	end

	assign res = res_s;

endmodule

`default_nettype wire

>>> src/smi_skid.sv
// Two-entry output buffer that decouples the pipeline from the result channel.
// Depends on smi_pkg.
`default_nettype none

module smi_skid import smi_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t din,
	input  wire logic pop_ready,
	output logic out_valid,
	output res_t dout,
	output logic full
);

	logic out_v_q, spare_v_q;
	res_t out_q, spare_q;
	logic pop;

	assign pop = out_v_q & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			spare_v_q <= 1'b0;
		end else if (spare_v_q) begin
			if (pop) begin
				spare_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_v_q || pop) begin
				out_v_q <= 1'b1;
			end else begin
				spare_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (spare_v_q) begin
			if (pop) begin
				out_q <= spare_q;
			end
		end else if (push) begin
			if (!out_v_q || pop) begin
				out_q <= din;
			end else begin
				spare_q <= din;
			end
		end
	end

	assign out_valid = out_v_q;
	assign dout = out_q;
	assign full = spare_v_q;

endmodule

`default_nettype wire

>>> src/small_matrix_inverse.sv
// Top level of the small matrix inverse; instantiates smi_front, smi_div and smi_skid.
// Depends on smi_pkg.
`default_nettype none

// Inverts one 2x2 or 3x3 signed Q16.16 matrix per request as adjugate over
// determinant, each entry rounded to nearest (ties away from zero) and
// saturated. The block takes one request every cycle while the result side
// keeps up. Each request passes seven stages of cofactor and determinant
// arithmetic and then, per entry, a 35-stage divider lane that resolves one
// quotient bit per stage. A two-entry output buffer lets the input keep
// flowing while a result waits. A zero determinant sets the singular flag and
// gives all-zero entries; in 2x2 mode the third row and column are zero. Write
// matrix_size only while no request is in flight.

module small_matrix_inverse import smi_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_wr_en,
	input  wire logic [1:0] cfg_wr_data,        // matrix_size
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [TDATA_W-1:0] s_axis_tdata, // m00,m01,m02,m10,m11,m12,m20,m21,m22
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,      // i00,i01,i02,i10,i11,i12,i20,i21,i22
	output logic m_axis_tuser                     // singular
);

	logic [1:0] matrix_size_q;
	logic en, full;
	cof_t cof;
	ctl_t ctl_s [LANE_LAT];
	dmag_t dmag_s [DIV_STEPS];
	logic [ENT_W-1:0] lane_res [N_ENT];
	res_t res_in, res_out;
	logic push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= SIZE_RST;
		end else if (cfg_wr_en) begin
			matrix_size_q <= cfg_wr_data;
		end
	end

	assign en = ~full;
	assign s_axis_tready = en;

	smi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.in_data  (s_axis_tdata),
		.mode_2x2 (matrix_size_q == SIZE_2X2),
		.cof      (cof)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < LANE_LAT; s++) begin
				ctl_s[s] <= '0;
			end
		end else if (en) begin
			ctl_s[0] <= '{valid: cof.valid, singular: cof.singular};
			for (int s = 1; s < LANE_LAT; s++) begin
				ctl_s[s] <= ctl_s[s-1];
			end
		end
	end

	// The divisor is shared by all nine lanes, one copy per quotient step.
	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s[0] <= cof.dmag;
			for (int s = 1; s < DIV_STEPS; s++) begin
				dmag_s[s] <= dmag_s[s-1];
			end
		end
	end

	for (genvar k = 0; k < N_ENT; k++) begin : g_lane
		smi_div u_div (
			.clk      (clk),
			.en       (en),
			.amag     (cof.amag[k]),
			.neg      (cof.neg[k]),
			.dmag_in  (cof.dmag),
			.dmag_stg (dmag_s),
			.res      (lane_res[k])
		);
	end

	always_comb begin
		res_in.singular = ctl_s[LANE_LAT-1].singular;
		for (int k = 0; k < N_ENT; k++) begin
			res_in.inv[k] = ctl_s[LANE_LAT-1].singular ? '0 : lane_res[k];
		end
	end

	assign push = en & ctl_s[LANE_LAT-1].valid;

	smi_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (res_in),
		.pop_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.dout      (res_out),
		.full      (full)
	);

	assign m_axis_tdata = res_out.inv;
	assign m_axis_tuser = res_out.singular;

endmodule

`default_nettype wire

>>> src/smi_checker.sv
// Port-level checks for the small matrix inverse, bound to the top level.
// Depends on smi_pkg and small_matrix_inverse_assert.svh.
`default_nettype none
`include "small_matrix_inverse_assert.svh"

module smi_port_checker import smi_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [TDATA_W-1:0] m_axis_tdata,
	input wire logic m_axis_tuser
);

	// A singular result carries only zero entries.
	`SMI_ASSERT_SAME(a_sing_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "singular result with nonzero entries")

	// The input is held back only when a result is already waiting and was not taken.
	`SMI_ASSERT_SAME(a_stall_cause, !s_axis_tready, m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready), "input stalled without a blocked result")

	// A result that is not taken stays put.
	`SMI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "waiting result changed")

endmodule

bind small_matrix_inverse smi_port_checker u_chk (.*);

`default_nettype wire
